// File: src/edd_pkg.sv
// edd_pkg: shared types and constants of the energy dispersal descrambler
// no dependencies; imported by every module of the block
`default_nettype none

package edd_pkg;

  // fixed field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PRBS_W = 15;
  // byte position width in a queue entry, covers packet lengths up to 256
  localparam int unsigned POS_W  = 8;

  // prbs register value after reset
  localparam logic [PRBS_W-1:0] PRBS_SEED_RST = 15'h00a9;

  // configuration register index (paddr bit 2)
  localparam logic REG_IDX_SEED = 1'b0;

  // input item
  typedef struct packed {
    logic [BYTE_W-1:0] data_in;
    logic              frame_start;
  } edd_in_t;

  // result item
  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              packet_start;
  } edd_out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic              sync;  // sync byte, passes straight out
    logic [POS_W-1:0]  addr;  // packet position
    logic [BYTE_W-1:0] data;  // descrambled byte, or raw sync byte
  } edd_ent_t;

endpackage : edd_pkg

`default_nettype wire

// File: src/edd_front.sv
// edd_front: accepts input bytes, tracks packet position, runs the prbs
// depends on edd_pkg
`default_nettype none

module edd_front #(
  parameter int unsigned PACKET_BYTES = 204
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [edd_pkg::PRBS_W-1:0]     seed_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire edd_pkg::edd_in_t               in_data_i,
  output logic                                push_o,
  output edd_pkg::edd_ent_t                   ent_o,
  input  wire logic                           full_i
);
  import edd_pkg::*;

  localparam int unsigned AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

  logic [PRBS_W-1:0] prbs_q, prbs_d, prbs_base;
  logic [AW-1:0]     pos_q, pos_d, pos_sel;
  logic [BYTE_W-1:0] key;
  logic              is_sync;
  logic              accept;

  // eight lfsr clocks of 1 + x^14 + x^15, first feedback bit is the key msb
  function automatic logic [BYTE_W+PRBS_W-1:0] prbs_step8(input logic [PRBS_W-1:0] st);
    logic [PRBS_W-1:0] s;
    logic [BYTE_W-1:0] k;
    logic              fb;
    s = st;
    k = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      fb = s[13] ^ s[14];
      s  = {s[PRBS_W-2:0], fb};
      k  = {k[BYTE_W-2:0], fb};
    end
    return {k, s};
  endfunction

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // frame start restarts the position and reseeds the prbs
  assign pos_sel   = in_data_i.frame_start ? '0 : pos_q;
  assign prbs_base = in_data_i.frame_start ? seed_i : prbs_q;
  assign {key, prbs_d} = prbs_step8(prbs_base);

  // classify the byte
  assign is_sync = (pos_sel == AW'(PACKET_BYTES - 1));
  assign pos_d   = is_sync ? '0 : pos_sel + AW'(1);

  assign push_o     = accept;
  assign ent_o.sync = is_sync;
  assign ent_o.addr = POS_W'(pos_sel);
  assign ent_o.data = is_sync ? in_data_i.data_in : (in_data_i.data_in ^ key);

  // position and prbs state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prbs_q <= PRBS_SEED_RST;
      pos_q  <= '0;
    end else if (accept) begin
      prbs_q <= prbs_d;
      pos_q  <= pos_d;
    end
  end

endmodule : edd_front

`default_nettype wire

// File: src/edd_queue.sv
// edd_queue: two-entry queue between front and back
// depends on edd_pkg
`default_nettype none

module edd_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire edd_pkg::edd_ent_t ent_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output edd_pkg::edd_ent_t      ent_o
);
  import edd_pkg::*;

  edd_ent_t   slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign ent_o   = slot_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= ent_i;
  end

endmodule : edd_queue

`default_nettype wire

// File: src/edd_back.sv
// edd_back: packet store access and output register
// depends on edd_pkg
`default_nettype none

module edd_back #(
  parameter int unsigned PACKET_BYTES = 204
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              ent_valid_i,
  input  wire edd_pkg::edd_ent_t ent_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output edd_pkg::edd_out_t      out_data_o
);
  import edd_pkg::*;

  localparam int unsigned AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

  logic [BYTE_W-1:0]       store_q [PACKET_BYTES];
  logic [PACKET_BYTES-1:0] vld_q;
  logic [AW-1:0]           addr;
  logic [BYTE_W-1:0]       rdata_q, sbyte_q;
  logic                    rvld_q, sync_q;
  logic                    out_valid_q;

  assign addr  = ent_i.addr[AW-1:0];
  assign pop_o = ent_valid_i && (!out_valid_q || !out_stall_i);

  // store: read old byte, write new non-sync byte there
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rdata_q <= store_q[addr];
      if (!ent_i.sync) store_q[addr] <= ent_i.data;
    end
  end

  // per-entry written flags, an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pop_o && !ent_i.sync) begin
      vld_q[addr] <= 1'b1;
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rvld_q  <= vld_q[addr];
      sync_q  <= ent_i.sync;
      sbyte_q <= ent_i.data;
    end
  end

  // output valid, held while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.packet_start = sync_q;
  assign out_data_o.data_out     = sync_q ? sbyte_q : (rvld_q ? rdata_q : '0);

endmodule : edd_back

`default_nettype wire

// File: src/energy_dispersal_descrambler_top.sv
// energy_dispersal_descrambler_top: prbs 1+x^14+x^15 descrambler with sync relocation
// depends on edd_pkg, edd_front, edd_queue, edd_back
//
// usage:
//  - input channel (in_valid_i / in_stall_o / in_data_i) takes one transport byte
//    per transfer with a frame start flag that reseeds the prbs and restarts
//    the packet position
//  - output channel (out_valid_o / out_stall_i / out_data_o) gives exactly one
//    byte per input transfer; the sync byte (last of a packet) comes out at
//    once with packet_start set, data bytes come from the previous packet
//  - apb port: register 0 at address 0 is the 15-bit prbs seed
//  - throughput is one byte per cycle while out_stall_i is low; the front keeps the
//    lfsr step, the back does one store read per byte, one store write per data byte
//  - an input transfer passes through a queue slot and then the registered store
//    read before out_valid_o rises
//  - reset clears the position, loads the prbs with 0xa9 and the seed with
//    0xa9, and marks every store entry unwritten so it reads as zero; there is
//    no clearing pass, bytes are taken from the first cycle after reset
//  - a stalled receiver holds the output register; the two-entry queue fills
//    and then in_stall_o rises
`default_nettype none

module energy_dispersal_descrambler_top #(
  parameter int unsigned PACKET_BYTES = 204
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire edd_pkg::edd_in_t  in_data_i,
  // output channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output edd_pkg::edd_out_t      out_data_o,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import edd_pkg::*;

  logic [PRBS_W-1:0] seed_q;
  logic              cfg_wr;
  logic              push, full, pop, ent_valid;
  edd_ent_t          ent_in, ent_out;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= PRBS_SEED_RST;
    end else if (cfg_wr && (paddr[2] == REG_IDX_SEED)) begin
      seed_q <= pwdata[PRBS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_IDX_SEED) ? 32'(seed_q) : 32'd0;

  // front: position and prbs
  edd_front #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .seed_i     (seed_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .ent_o      (ent_in),
    .full_i     (full)
  );

  // decoupling queue
  edd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (ent_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (ent_valid),
    .ent_o   (ent_out)
  );

  // back: packet store and output
  edd_back #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (ent_valid),
    .ent_i       (ent_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule : energy_dispersal_descrambler_top

`default_nettype wire

// File: dv/energy_dispersal_descrambler_top_tb.sv
`timescale 1ns / 100ps
// energy_dispersal_descrambler_top_tb: self-checking bench for the prbs descrambler
// depends on edd_pkg and energy_dispersal_descrambler_top; streams random packets,
// rewrites the seed over apb between phases and checks every output transfer in order

module energy_dispersal_descrambler_top_tb;
  import edd_pkg::*;

  localparam int unsigned PKT_LEN      = 204;
  localparam int unsigned RUN_LIMIT    = 200000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [2:0]  ADDR_SEED    = 3'd0;
  localparam logic [2:0]  ADDR_SPARE   = 3'd4;

  // clock, reset and block ports
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  edd_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  edd_out_t    out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // descrambler mirror state
  logic [PRBS_W-1:0] seed_q = PRBS_SEED_RST;
  logic [PRBS_W-1:0] lfsr_q = PRBS_SEED_RST;
  logic [POS_W-1:0]  pos_q  = '0;
  logic [BYTE_W-1:0] store_q [PKT_LEN];

  // pending input bytes and expected output bytes
  edd_in_t     byte_q [$];
  edd_out_t    expected_q [$];
  edd_out_t    want;
  int unsigned queued_cnt = 0;
  int unsigned sent_cnt   = 0;
  int unsigned errors     = 0;
  int unsigned cycles     = 0;
  int unsigned in_gap     = 0;
  int unsigned out_gap    = 0;
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  logic [31:0] rd_val;

  energy_dispersal_descrambler_top #(
    .PACKET_BYTES(PKT_LEN)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  // advance the mirror by one byte and return the byte it puts out
  function automatic edd_out_t descramble_byte(edd_in_t item);
    edd_out_t          res;
    logic [BYTE_W-1:0] key;
    logic              fb;
    int unsigned       p;
    int                k;
    if (item.frame_start) begin
      lfsr_q = seed_q;
      pos_q  = '0;
    end
    p = (pos_q >= PKT_LEN) ? 0 : pos_q;
    // eight prbs clocks, first feedback bit lands in the msb of the key
    key = '0;
    for (k = 0; k < 8; k++) begin
      fb     = lfsr_q[13] ^ lfsr_q[14];
      lfsr_q = {lfsr_q[13:0], fb};
      key    = {key[6:0], fb};
    end
    if (p == PKT_LEN - 1) begin
      // sync byte goes straight out and opens the output packet
      res.data_out     = item.data_in;
      res.packet_start = 1'b1;
      pos_q            = '0;
    end else begin
      res.data_out     = store_q[p];
      res.packet_start = 1'b0;
      store_q[p]       = item.data_in ^ key;
      pos_q            = POS_W'(p + 1);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_v, act_v);
  endtask

  // input driver: one transfer per cycle unless an idle burst runs or the block stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(descramble_byte(in_data_i));
        sent_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (byte_q.size() != 0 && $urandom_range(99, 0) < in_idle_pct) begin
          in_gap = $urandom_range(9, 0);
          in_valid_i <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= byte_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor: compares each transfer with the oldest expected byte
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected output", '0, 32'(out_data_o));
        end else begin
          want = expected_q.pop_front();
          if (out_data_o.data_out !== want.data_out)
            report_mismatch("data_out", 32'(want.data_out), 32'(out_data_o.data_out));
          if (out_data_o.packet_start !== want.packet_start)
            report_mismatch("packet_start", 32'(want.packet_start),
                            32'(out_data_o.packet_start));
        end
      end
      // receiver stall bursts
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(99, 0) < out_idle_pct) begin
        out_gap = $urandom_range(9, 0);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("energy_dispersal_descrambler_top regression: fail");
      $finish;
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // writes to the spare index are dropped by the block
    if (addr[2] == REG_IDX_SEED)
      seed_q = data[PRBS_W-1:0];
  endtask

  task automatic apb_check_seed();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_SEED;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd_val = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd_val !== {17'b0, seed_q})
      report_mismatch("seed readback", {17'b0, seed_q}, rd_val);
  endtask

  task automatic add_byte(logic [BYTE_W-1:0] data, logic fs);
    edd_in_t item;
    item.data_in     = data;
    item.frame_start = fs;
    byte_q.push_back(item);
    queued_cnt++;
  endtask

  // aligned packets of random bytes, now and then broken by a mid-packet frame start
  task automatic add_stream(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      add_byte(BYTE_W'($urandom_range(255, 0)), (i == 0) || ($urandom_range(249, 0) == 0));
  endtask

  // hold the sender until every transfer has been accepted and checked
  task automatic finish_phase();
    while (sent_cnt != queued_cnt) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // test sequence
  initial begin
    foreach (store_q[i]) store_q[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset prbs, field extremes, back-to-back and mid-packet reseeds
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'haa, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hff, 1'b1);
    add_byte(8'h00, 1'b1);
    add_byte(8'h7f, 1'b0);
    add_byte(8'hfe, 1'b0);
    add_byte(8'h0f, 1'b0);
    add_byte(8'hf0, 1'b0);
    add_byte(8'hc3, 1'b1);
    add_byte(8'h3c, 1'b0);
    add_byte(8'ha5, 1'b0);
    add_byte(8'h5a, 1'b0);
    finish_phase();
    apb_check_seed();

    // zero seed leaves data unscrambled
    in_idle_pct  = 10;
    out_idle_pct = 10;
    apb_write(ADDR_SEED, 32'h0000_0000);
    apb_check_seed();
    add_stream(230);
    finish_phase();

    // all-ones write, upper bits dropped
    in_idle_pct  = 5;
    out_idle_pct = 30;
    apb_write(ADDR_SEED, 32'hffff_ffff);
    apb_check_seed();
    add_stream(420);
    finish_phase();

    // spare index write is ignored, then a random seed
    in_idle_pct  = 25;
    out_idle_pct = 5;
    apb_write(ADDR_SPARE, $urandom());
    apb_check_seed();
    apb_write(ADDR_SEED, $urandom());
    apb_check_seed();
    add_stream(420);
    finish_phase();

    // back to the reset seed, full rate on both sides
    in_idle_pct  = 0;
    out_idle_pct = 0;
    apb_write(ADDR_SEED, {17'b0, PRBS_SEED_RST});
    apb_check_seed();
    add_stream(280);
    finish_phase();

    if (errors == 0) begin
      $display("energy_dispersal_descrambler_top regression: pass");
    end else begin
      $display("energy_dispersal_descrambler_top regression: fail");
    end
    $finish;
  end

endmodule
